[sv/dss_pkg.sv]
// Shared constants, types and helper functions of the disk seek scheduler.
`timescale 1ns / 1ps

package dss_pkg;

   localparam int MAX_REQUESTS = 32;
   localparam int TRACK_W      = 16;
   localparam int SEEK_W       = 22;
   localparam int POLICY_W     = 3;
   localparam int TRACKS_W     = 17;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 17;

   localparam int IDX_BITS = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_BITS = $clog2(MAX_REQUESTS + 1);

   localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_TRACKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TRACK = 2'd2;

   localparam logic [POLICY_W-1:0] POLICY_FCFS    = 3'd0;
   localparam logic [POLICY_W-1:0] POLICY_SSTF    = 3'd1;
   localparam logic [POLICY_W-1:0] POLICY_SCAN_LO = 3'd2;
   localparam logic [POLICY_W-1:0] POLICY_SCAN_HI = 3'd3;
   localparam logic [POLICY_W-1:0] POLICY_CSCAN   = 3'd4;

   localparam logic [TRACKS_W-1:0] TRACKS_RESET = 17'h10000;

   typedef struct packed {
      logic accept;
      logic store;
      logic init;
      logic scan_start;
      logic scan_run;
      logic visit;
      logic next_phase;
      logic finish;
   } dss_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic more_phase;
      logic out_free;
   } dss_status_type;

   function automatic logic [TRACK_W-1:0] track_dist(input logic [TRACK_W-1:0] a,
                                                     input logic [TRACK_W-1:0] b);
      track_dist = (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [SEEK_W-1:0] seek_add(input logic [SEEK_W-1:0]  seek,
                                                  input logic [TRACK_W-1:0] amount);
      logic [SEEK_W:0] sum;
      sum      = {1'b0, seek} + (SEEK_W + 1)'(amount);
      seek_add = sum[SEEK_W] ? SEEK_MAX : sum[SEEK_W-1:0];
   endfunction

endpackage

[sv/dss_req_if.sv]
// Request channel: one pending track request per transaction.
`timescale 1ns / 1ps

interface dss_req_if
   import dss_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [TRACK_W-1:0] track;
   logic               last;

   modport source (output valid, output track, output last, input ready);
   modport sink   (input valid, input track, input last, output ready);
endinterface

[sv/dss_rsp_if.sv]
// Response channel: one head visit per transaction.
`timescale 1ns / 1ps

interface dss_rsp_if
   import dss_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [TRACK_W-1:0] track_res;
   logic [SEEK_W-1:0]  total_seek;
   logic               last_res;

   modport source (output valid, output track_res, output total_seek, output last_res,
                   input ready);
   modport sink   (input valid, input track_res, input total_seek, input last_res,
                   output ready);
endinterface

[sv/dss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

[sv/dss_ctrl.sv]
// Sequencing state machine: batch load, candidate scans, visit emission.
`timescale 1ns / 1ps

module dss_ctrl
   import dss_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_last,
   input  dss_status_type status,
   output dss_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_INIT,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            cmd.accept = 1'b1;
            if (req_valid) begin
               cmd.store = 1'b1;
               if (req_last) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd.init       = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.found) begin
               if (status.out_free) begin
                  cmd.visit      = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end else if (status.more_phase) begin
               cmd.next_phase = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/dss_datapath.sv]
// Datapath: registers, request store, candidate compare, seek accumulate, output stage.
`timescale 1ns / 1ps

module dss_datapath
   import dss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [TRACK_W-1:0]    req_track,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [TRACK_W-1:0]    rsp_track_res,
   output logic [SEEK_W-1:0]     rsp_total_seek,
   output logic                  rsp_last_res,
   input  dss_cmd_type           cmd,
   output dss_status_type        status
);

   typedef enum logic [1:0] {
      CLS_ANY,
      CLS_LO,
      CLS_HI
   } cls_type;

   typedef enum logic [1:0] {
      ORD_FIRST,
      ORD_LESS,
      ORD_MORE
   } ord_type;

   logic [POLICY_W-1:0]     policy_ff, policy_in;
   logic [TRACKS_W-1:0]     disk_tracks_ff, disk_tracks_in;
   logic [TRACK_W-1:0]      start_track_ff, start_track_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [MAX_REQUESTS-1:0] served_ff, served_in;
   logic [TRACK_W-1:0]      head_ff, head_in;
   logic [SEEK_W-1:0]       seek_ff, seek_in;
   logic                    phase_ff, phase_in;
   logic                    virt_pend_ff, virt_pend_in;
   logic [TRACK_W-1:0]      virt_val_ff, virt_val_in;
   logic [TRACK_W-1:0]      pend_track_ff, pend_track_in;
   logic [SEEK_W-1:0]       pend_seek_ff, pend_seek_in;
   logic [CNT_BITS-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [IDX_BITS-1:0]     rd_idx_ff, rd_idx_in;
   logic                    best_found_ff, best_found_in;
   logic                    best_virt_ff, best_virt_in;
   logic [IDX_BITS-1:0]     best_idx_ff, best_idx_in;
   logic [TRACK_W-1:0]      best_key_ff, best_key_in;
   logic [TRACK_W-1:0]      best_track_ff, best_track_in;
   logic                    out_valid_ff, out_valid_in;
   logic [TRACK_W-1:0]      out_track_ff, out_track_in;
   logic [SEEK_W-1:0]       out_seek_ff, out_seek_in;
   logic                    out_last_ff, out_last_in;

   logic                    ram_we;
   logic [TRACK_W-1:0]      ram_rdata;
   logic [TRACK_W-1:0]      top;
   logic                    is_scan;
   cls_type                 cls;
   ord_type                 ord;
   logic                    class_ok;
   logic [TRACK_W-1:0]      cand_key;
   logic                    cand_better;
   logic [SEEK_W-1:0]       visit_seek;

   dss_ram #(
      .WIDTH (TRACK_W),
      .DEPTH (MAX_REQUESTS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[IDX_BITS-1:0]),
      .wdata (req_track),
      .raddr (rd_cnt_ff[IDX_BITS-1:0]),
      .rdata (ram_rdata)
   );

   // top track: zero count gives 0, counts above the track range saturate
   always_comb begin
      if (disk_tracks_ff == '0) begin
         top = '0;
      end else if (disk_tracks_ff[TRACKS_W-1] && (disk_tracks_ff[TRACK_W-1:0] != '0)) begin
         top = '1;
      end else begin
         top = TRACK_W'(disk_tracks_ff - TRACKS_W'(1));
      end
   end

   always_comb begin
      is_scan = 1'b0;
      cls     = CLS_ANY;
      ord     = ORD_FIRST;
      case (policy_ff)
         POLICY_SSTF: begin
            ord = ORD_LESS;
         end
         POLICY_SCAN_LO: begin
            is_scan = 1'b1;
            cls     = phase_ff ? CLS_HI : CLS_LO;
            ord     = phase_ff ? ORD_LESS : ORD_MORE;
         end
         POLICY_SCAN_HI: begin
            is_scan = 1'b1;
            cls     = phase_ff ? CLS_LO : CLS_HI;
            ord     = phase_ff ? ORD_MORE : ORD_LESS;
         end
         POLICY_CSCAN: begin
            is_scan = 1'b1;
            cls     = phase_ff ? CLS_LO : CLS_HI;
            ord     = ORD_LESS;
         end
         default: begin
            ord = ORD_FIRST;
         end
      endcase
   end

   always_comb begin
      case (cls)
         CLS_LO:  class_ok = ram_rdata < start_track_ff;
         CLS_HI:  class_ok = ram_rdata > start_track_ff;
         default: class_ok = 1'b1;
      endcase
      cand_key = (policy_ff == POLICY_SSTF) ? track_dist(ram_rdata, head_ff) : ram_rdata;
      case (ord)
         ORD_LESS: cand_better = !best_found_ff || (cand_key < best_key_ff);
         ORD_MORE: cand_better = !best_found_ff || (cand_key > best_key_ff);
         default:  cand_better = !best_found_ff;
      endcase
      cand_better = cand_better && rd_valid_ff && !served_ff[rd_idx_ff] && class_ok;
   end

   assign visit_seek = seek_add(seek_ff, track_dist(best_track_ff, head_ff));
   assign ram_we     = cmd.store && (count_ff < CNT_BITS'(MAX_REQUESTS));

   always_comb begin
      policy_in      = policy_ff;
      disk_tracks_in = disk_tracks_ff;
      start_track_in = start_track_ff;
      count_in       = count_ff;
      served_in      = served_ff;
      head_in        = head_ff;
      seek_in        = seek_ff;
      phase_in       = phase_ff;
      virt_pend_in   = virt_pend_ff;
      virt_val_in    = virt_val_ff;
      pend_track_in  = pend_track_ff;
      pend_seek_in   = pend_seek_ff;
      rd_cnt_in      = rd_cnt_ff;
      rd_valid_in    = rd_valid_ff;
      rd_idx_in      = rd_idx_ff;
      best_found_in  = best_found_ff;
      best_virt_in   = best_virt_ff;
      best_idx_in    = best_idx_ff;
      best_key_in    = best_key_ff;
      best_track_in  = best_track_ff;
      out_valid_in   = out_valid_ff;
      out_track_in   = out_track_ff;
      out_seek_in    = out_seek_ff;
      out_last_in    = out_last_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_POLICY:      policy_in      = csr_wdata[POLICY_W-1:0];
            CSR_DISK_TRACKS: disk_tracks_in = csr_wdata[TRACKS_W-1:0];
            CSR_START_TRACK: start_track_in = csr_wdata[TRACK_W-1:0];
            default:         policy_in      = policy_ff;
         endcase
      end

      if (ram_we) begin
         count_in = count_ff + CNT_BITS'(1);
      end

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.init) begin
         head_in       = start_track_ff;
         seek_in       = '0;
         pend_track_in = start_track_ff;
         pend_seek_in  = '0;
         served_in     = '0;
         phase_in      = 1'b0;
         virt_pend_in  = is_scan;
         virt_val_in   = (policy_ff == POLICY_SCAN_LO) ? '0 : top;
      end

      if (cmd.scan_run) begin
         if (rd_cnt_ff < count_ff) begin
            rd_valid_in = 1'b1;
            rd_idx_in   = rd_cnt_ff[IDX_BITS-1:0];
            rd_cnt_in   = rd_cnt_ff + CNT_BITS'(1);
         end else begin
            rd_valid_in = 1'b0;
         end
         if (cand_better) begin
            best_found_in = 1'b1;
            best_virt_in  = 1'b0;
            best_idx_in   = rd_idx_ff;
            best_key_in   = cand_key;
            best_track_in = ram_rdata;
         end
      end

      if (cmd.visit) begin
         out_valid_in  = 1'b1;
         out_track_in  = pend_track_ff;
         out_seek_in   = pend_seek_ff;
         out_last_in   = 1'b0;
         pend_track_in = best_track_ff;
         pend_seek_in  = visit_seek;
         seek_in       = visit_seek;
         head_in       = best_track_ff;
         if (best_virt_ff) begin
            virt_pend_in = 1'b0;
         end else begin
            served_in[best_idx_ff] = 1'b1;
         end
      end

      // C-SCAN wraps to track 0: the return sweep counts as top-track travel
      if (cmd.next_phase) begin
         phase_in = 1'b1;
         if (policy_ff == POLICY_CSCAN) begin
            head_in      = '0;
            seek_in      = seek_add(seek_ff, top);
            virt_pend_in = 1'b1;
            virt_val_in  = '0;
         end else begin
            virt_pend_in = 1'b0;
         end
      end

      if (cmd.finish) begin
         out_valid_in = 1'b1;
         out_track_in = pend_track_ff;
         out_seek_in  = pend_seek_ff;
         out_last_in  = 1'b1;
         count_in     = '0;
      end

      // the added end track seeds the search of its sweep
      if (cmd.scan_start) begin
         rd_cnt_in     = '0;
         rd_valid_in   = 1'b0;
         best_found_in = virt_pend_in;
         best_virt_in  = 1'b1;
         best_idx_in   = '0;
         best_key_in   = virt_val_in;
         best_track_in = virt_val_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff      <= POLICY_FCFS;
         disk_tracks_ff <= TRACKS_RESET;
         start_track_ff <= '0;
         count_ff       <= '0;
         served_ff      <= '0;
         head_ff        <= '0;
         seek_ff        <= '0;
         phase_ff       <= 1'b0;
         virt_pend_ff   <= 1'b0;
         rd_cnt_ff      <= '0;
         rd_valid_ff    <= 1'b0;
         best_found_ff  <= 1'b0;
         best_virt_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         policy_ff      <= policy_in;
         disk_tracks_ff <= disk_tracks_in;
         start_track_ff <= start_track_in;
         count_ff       <= count_in;
         served_ff      <= served_in;
         head_ff        <= head_in;
         seek_ff        <= seek_in;
         phase_ff       <= phase_in;
         virt_pend_ff   <= virt_pend_in;
         rd_cnt_ff      <= rd_cnt_in;
         rd_valid_ff    <= rd_valid_in;
         best_found_ff  <= best_found_in;
         best_virt_ff   <= best_virt_in;
         out_valid_ff   <= out_valid_in;
      end
      virt_val_ff   <= virt_val_in;
      pend_track_ff <= pend_track_in;
      pend_seek_ff  <= pend_seek_in;
      rd_idx_ff     <= rd_idx_in;
      best_idx_ff   <= best_idx_in;
      best_key_ff   <= best_key_in;
      best_track_ff <= best_track_in;
      out_track_ff  <= out_track_in;
      out_seek_ff   <= out_seek_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_track_res  = out_track_ff;
   assign rsp_total_seek = out_seek_ff;
   assign rsp_last_res   = out_last_ff;

   assign status.scan_done  = (rd_cnt_ff == count_ff) && !rd_valid_ff;
   assign status.found      = best_found_ff;
   assign status.more_phase = is_scan && !phase_ff;
   assign status.out_free   = !out_valid_ff || rsp_ready;

endmodule

[sv/disk_seek_scheduler.sv]
// Disk seek scheduler top level: FCFS, SSTF, SCAN and C-SCAN service order.
//
//   Channel   Dir  Contents
//   req_chan  in   track, last: one request per transaction, last starts the schedule
//   rsp_chan  out  track_res, total_seek, last_res: one head visit per transaction
//   csr_*     in   write enable, register index, write data (policy, disk_tracks, start_track)
//
// Each visit costs a sweep of the stored requests, one entry a cycle through the RAM's
// single read port, then one decide state. SCAN policies add one more sweep at the turn.
// Requests are refused while a schedule runs. Synchronous active-high reset; the store
// needs no clearing. Stalls on rsp_chan hold the schedule in place with no loss.
`timescale 1ns / 1ps

module disk_seek_scheduler
   import dss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dss_req_if.sink               req_chan,
   dss_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dss_cmd_type    cmd;
   dss_status_type status;

   dss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .status    (status),
      .cmd       (cmd)
   );

   dss_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_track      (req_chan.track),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_track_res  (rsp_chan.track_res),
      .rsp_total_seek (rsp_chan.total_seek),
      .rsp_last_res   (rsp_chan.last_res),
      .cmd            (cmd),
      .status         (status)
   );

   assign req_chan.ready = cmd.accept;

endmodule

[test/tb_top.sv]
// Testbench for the disk seek scheduler: random request batches, predicted visit order checked.
`timescale 1ns / 1ps

module tb_top;
   import dss_pkg::*;

   localparam logic [POLICY_W-1:0] POLICY_SPARE = 3'd7;
   localparam int unsigned SEEK_CAP  = (1 << SEEK_W) - 1;
   localparam int unsigned TRACK_TOP = (1 << TRACK_W) - 1;
   localparam int RANDOM_ITEMS = 200;
   localparam int DRAIN        = 40;
   localparam int LIMIT        = 1000000;

   typedef struct packed {
      logic [TRACK_W-1:0] track;
      logic               last;
   } req_item_type;

   typedef struct packed {
      logic [TRACK_W-1:0] track;
      logic [SEEK_W-1:0]  seek;
      logic               last;
   } visit_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dss_req_if req_chan ();
   dss_rsp_if rsp_chan ();

   disk_seek_scheduler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow registers and scheduler state
   logic [POLICY_W-1:0] cfg_policy = POLICY_FCFS;
   logic [TRACKS_W-1:0] cfg_tracks = TRACKS_RESET;
   logic [TRACK_W-1:0]  cfg_start  = '0;
   logic [TRACK_W-1:0]  batch_tracks[$];
   logic [TRACK_W-1:0]  plan_head;
   int unsigned         plan_seek;
   visit_type           visits_due[$];

   req_item_type requests_queued[$];
   req_item_type req_next;
   bit        req_busy = 1'b0;
   bit        calm = 1'b0;
   int        req_gap = 0;
   int        rsp_gap = 0;
   int        errors = 0;
   int        cycles = 0;
   int        items_made = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string what);
      errors++;
      $display("tb_top: mismatch at %0t ns: %s", $time, what);
   endtask

   function automatic void move_head(input logic [TRACK_W-1:0] trk, input bit record);
      int unsigned d;
      visit_type   v;
      d = (trk > plan_head) ? trk - plan_head : plan_head - trk;
      plan_seek = (plan_seek + d > SEEK_CAP) ? SEEK_CAP : plan_seek + d;
      plan_head = trk;
      if (record) begin
         v.track = trk;
         v.seek  = SEEK_W'(plan_seek);
         v.last  = 1'b0;
         visits_due.insert(visits_due.size(), v);
      end
   endfunction

   function automatic void plan_schedule();
      logic [TRACK_W-1:0] side_trk [2][MAX_REQUESTS+1];
      int                 side_cnt [2];
      bit                 taken [MAX_REQUESTS];
      logic [TRACK_W-1:0] top, h0, v;
      int                 best, s, j;
      int unsigned        d, best_d, span;
      visit_type          final_visit;

      span = cfg_tracks;
      top = (span == 0) ? '0 : (span - 1 > TRACK_TOP) ? TRACK_W'(TRACK_TOP) : TRACK_W'(span - 1);
      h0 = cfg_start;
      plan_head = h0;
      plan_seek = 0;
      move_head(h0, 1'b1);
      side_cnt[0] = 0;
      side_cnt[1] = 0;
      case (cfg_policy)
         POLICY_SSTF: begin
            for (int k = 0; k < batch_tracks.size(); k++) begin
               best = -1;
               best_d = 0;
               for (int i = 0; i < batch_tracks.size(); i++) begin
                  d = (batch_tracks[i] > plan_head) ? batch_tracks[i] - plan_head
                                                    : plan_head - batch_tracks[i];
                  if (!taken[i] && (best < 0 || d < best_d)) begin
                     best = i;
                     best_d = d;
                  end
               end
               taken[best] = 1'b1;
               move_head(batch_tracks[best], 1'b1);
            end
         end
         POLICY_SCAN_LO, POLICY_SCAN_HI, POLICY_CSCAN: begin
            // ends of the disk first, then requests off the start track
            for (int i = -2; i < int'(batch_tracks.size()); i++) begin
               s = -1;
               if (i == -2 && cfg_policy != POLICY_SCAN_HI) begin
                  v = '0;
                  s = 0;
               end else if (i == -1 && cfg_policy != POLICY_SCAN_LO) begin
                  v = top;
                  s = 1;
               end else if (i >= 0 && batch_tracks[i] != h0) begin
                  v = batch_tracks[i];
                  s = (v < h0) ? 0 : 1;
               end
               if (s >= 0) begin
                  j = side_cnt[s];
                  while (j > 0 && side_trk[s][j-1] > v) begin
                     side_trk[s][j] = side_trk[s][j-1];
                     j--;
                  end
                  side_trk[s][j] = v;
                  side_cnt[s]++;
               end
            end
            if (cfg_policy == POLICY_SCAN_LO)
               for (int i = side_cnt[0] - 1; i >= 0; i--) move_head(side_trk[0][i], 1'b1);
            for (int i = 0; i < side_cnt[1]; i++) move_head(side_trk[1][i], 1'b1);
            if (cfg_policy == POLICY_SCAN_HI)
               for (int i = side_cnt[0] - 1; i >= 0; i--) move_head(side_trk[0][i], 1'b1);
            if (cfg_policy == POLICY_CSCAN) begin
               // return sweep costs the full top track
               plan_head = top;
               move_head('0, 1'b0);
               for (int i = 0; i < side_cnt[0]; i++) move_head(side_trk[0][i], 1'b1);
            end
         end
         default: begin
            for (int i = 0; i < batch_tracks.size(); i++) move_head(batch_tracks[i], 1'b1);
         end
      endcase
      final_visit = visits_due.pop_back();
      final_visit.last = 1'b1;
      visits_due.insert(visits_due.size(), final_visit);
      batch_tracks.delete();
   endfunction

   function automatic void note_request(input logic [TRACK_W-1:0] trk, input logic lst);
      if (batch_tracks.size() < MAX_REQUESTS) batch_tracks.insert(batch_tracks.size(), trk);
      if (lst) plan_schedule();
   endfunction

   task automatic check_visit(input logic [TRACK_W-1:0] trk, input logic [SEEK_W-1:0] seek,
                              input logic lst);
      visit_type want;
      if (visits_due.size() == 0) begin
         report($sformatf("unexpected visit track %0d seek %0d", trk, seek));
      end else begin
         want = visits_due.pop_front();
         if (trk !== want.track)
            report($sformatf("track_res %0d, want %0d", trk, want.track));
         if (seek !== want.seek)
            report($sformatf("total_seek %0d, want %0d (track %0d)", seek, want.seek, want.track));
         if (lst !== want.last)
            report($sformatf("last_res %0b, want %0b (track %0d)", lst, want.last, want.track));
      end
   endtask

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            req_busy = 1'b0;
            note_request(req_chan.track, req_chan.last);
         end
         if (rsp_chan.valid && rsp_chan.ready)
            check_visit(rsp_chan.track_res, rsp_chan.total_seek, rsp_chan.last_res);
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_busy && requests_queued.size() != 0) begin
            if (req_gap == 0 && !calm && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 15);
            if (req_gap > 0) begin
               req_gap--;
            end else begin
               req_next = requests_queued.pop_front();
               req_busy = 1'b1;
               req_chan.track <= req_next.track;
               req_chan.last  <= req_next.last;
            end
         end
         req_chan.valid <= req_busy;
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_gap == 0 && !calm && $urandom_range(0, 7) == 0) rsp_gap = $urandom_range(1, 15);
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_POLICY:      cfg_policy = val[POLICY_W-1:0];
         CSR_DISK_TRACKS: cfg_tracks = val[TRACKS_W-1:0];
         CSR_START_TRACK: cfg_start  = val[TRACK_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_regs(input logic [POLICY_W-1:0] pol, input logic [TRACKS_W-1:0] span,
                           input logic [TRACK_W-1:0] home);
      write_reg(CSR_POLICY, CSR_DATA_W'(pol));
      write_reg(CSR_DISK_TRACKS, span);
      write_reg(CSR_START_TRACK, CSR_DATA_W'(home));
   endtask

   task automatic push_req(input logic [TRACK_W-1:0] trk, input logic lst);
      req_item_type it;
      it.track = trk;
      it.last  = lst;
      requests_queued.insert(requests_queued.size(), it);
      items_made++;
   endtask

   // waits out the schedule, then lets the controller go idle
   task automatic settle();
      while (requests_queued.size() != 0 || req_busy || visits_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   function automatic logic [TRACK_W-1:0] pick_track();
      case ($urandom_range(0, 5))
         0:       return cfg_start;
         1:       return cfg_start + TRACK_W'($urandom_range(0, 15)) - 8;
         2:       return $urandom_range(0, 1) ? {TRACK_W{1'b1}} : {TRACK_W{1'b0}};
         default: return TRACK_W'($urandom);
      endcase
   endfunction

   initial begin
      logic [POLICY_W-1:0] pol;
      logic [TRACKS_W-1:0] span;
      logic [TRACK_W-1:0]  home;
      int                  size;

      req_chan.valid = 1'b0;
      req_chan.track = '0;
      req_chan.last  = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_we    = 1'b0;
      csr_index = CSR_POLICY;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: FCFS from track 0, field extremes
      push_req(16'hFFFF, 1'b0);
      push_req(16'h0000, 1'b0);
      push_req(16'h0001, 1'b1);
      settle();
      // SSTF tie goes to the earlier request
      set_regs(POLICY_SSTF, 17'd1000, 16'd100);
      push_req(16'd90, 1'b0);
      push_req(16'd110, 1'b0);
      push_req(16'd100, 1'b0);
      push_req(16'd50, 1'b1);
      settle();
      // start track dropped, duplicates kept
      set_regs(POLICY_SCAN_LO, 17'd200, 16'd100);
      push_req(16'd100, 1'b0);
      push_req(16'd20, 1'b0);
      push_req(16'd150, 1'b0);
      push_req(16'd20, 1'b1);
      settle();
      // zero track count
      set_regs(POLICY_SCAN_HI, 17'd0, 16'd5);
      push_req(16'd5, 1'b0);
      push_req(16'd3, 1'b0);
      push_req(16'd300, 1'b1);
      settle();
      // track count above the track range
      set_regs(POLICY_CSCAN, {TRACKS_W{1'b1}}, 16'hFFFF);
      push_req(16'hFFFF, 1'b0);
      push_req(16'd7, 1'b0);
      push_req(16'd40000, 1'b1);
      settle();
      // unused policy code, one-request batch
      set_regs(POLICY_SPARE, 17'd1, 16'd0);
      push_req(16'd42, 1'b1);
      settle();

      while (items_made < RANDOM_ITEMS) begin
         calm = (items_made > RANDOM_ITEMS * 4 / 5) || ($urandom_range(0, 3) == 0);
         pol = ($urandom_range(0, 4) == 0) ? POLICY_W'($urandom_range(0, 7))
                                           : POLICY_W'($urandom_range(0, 4));
         case ($urandom_range(0, 5))
            0:       span = '0;
            1:       span = 17'd1;
            2:       span = TRACKS_RESET;
            3:       span = {TRACKS_W{1'b1}};
            4:       span = TRACKS_W'($urandom_range(2, 4096));
            default: span = TRACKS_W'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0:       home = '0;
            1:       home = {TRACK_W{1'b1}};
            default: home = TRACK_W'($urandom);
         endcase
         set_regs(pol, span, home);
         repeat ($urandom_range(1, 3)) begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
            for (int i = 0; i < size; i++) push_req(pick_track(), i == size - 1);
         end
         settle();
      end

      if (errors == 0 && visits_due.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/dss_pkg.sv
sv/dss_req_if.sv
sv/dss_rsp_if.sv
sv/dss_ram.sv
sv/dss_ctrl.sv
sv/dss_datapath.sv
sv/disk_seek_scheduler.sv
test/tb_top.sv
